/* sv/svs_pkg.sv */
// Shared constants and types for the searchable value stack.
// Holds request codes, status codes and field widths; no dependencies.
`timescale 1ns / 1ps

package svs_pkg;

  // Default number of stack entries
  localparam int SVS_DEPTH = 64;

  // Fixed payload widths
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_PEEK     = 3'd2,
    REQ_CONTAINS = 3'd3,
    REQ_COUNT    = 3'd4,
    REQ_REMOVE   = 3'd5
  } req_code_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

/* sv/svs_ifs.sv */
// Valid/ready channel interfaces for the searchable value stack.
// Depends on svs_pkg for payload widths.
`timescale 1ns / 1ps

// Request channel: operation code and operand
interface svs_req_if;
  logic                              valid;
  logic                              ready;
  logic [svs_pkg::REQ_W-1:0]         req_type;
  logic signed [svs_pkg::DATA_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

// Result channel: one result per request
interface svs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [svs_pkg::DATA_W-1:0] data_out;
  logic                              found;
  logic [svs_pkg::CNT_W-1:0]         match_count;
  logic [svs_pkg::CNT_W-1:0]         depth_now;
  logic [svs_pkg::STAT_W-1:0]        status;

  modport source (output valid, data_out, found, match_count, depth_now, status,
                  input ready);
  modport sink   (input valid, data_out, found, match_count, depth_now, status,
                  output ready);
endinterface

/* sv/searchable_value_stack.sv */
// Flow: push and unused codes go straight to the done state; pop/peek pass
// through a top-entry read; contains/count/remove walk the stack through the
// single read port of the entry memory, one entry per cycle.
// Throughput: one request at a time; the next is taken once the result sits
// in the output register, which may still wait for its sink.
// Reset: synchronous active-low; clears depth and control, store left as is.
`timescale 1ns / 1ps

module searchable_value_stack #(
  parameter int DEPTH = svs_pkg::SVS_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  svs_req_if.sink    in_req,
  svs_rsp_if.source  out_rsp
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW  = $clog2(DEPTH + 1);
  localparam int DW  = svs_pkg::DATA_W;
  localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);
  localparam logic [LW-1:0] ONE      = LW'(1);

  typedef enum logic [1:0] {S_IDLE, S_TOP, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] rd_idx_r, rd_idx_nxt;
  logic [LW-1:0] wr_r, wr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [svs_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [DW-1:0] val_r, val_nxt;

  // Pending result
  logic [DW-1:0]              res_data_r, res_data_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [LW-1:0]              res_cnt_r, res_cnt_nxt;
  logic [svs_pkg::STAT_W-1:0] res_status_r, res_status_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              out_data_r, out_data_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [svs_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [svs_pkg::CNT_W-1:0]  out_depth_r, out_depth_nxt;
  logic [svs_pkg::STAT_W-1:0] out_status_r, out_status_nxt;

  // Memory port
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] mem_ra;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic          mem_we;

  logic acc;
  logic hit;
  logic issue;

  assign acc          = in_req.valid && (state_r == S_IDLE);
  assign in_req.ready = (state_r == S_IDLE);
  assign hit          = (rd_data_r == val_r);
  assign issue        = (rd_idx_r < fill_r);

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.data_out    = out_data_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.match_count = out_cnt_r;
  assign out_rsp.depth_now   = out_depth_r;
  assign out_rsp.status      = out_status_r;

  // Next-state and memory control
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    wr_nxt         = wr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    req_nxt        = req_r;
    val_nxt        = val_r;
    res_data_nxt   = res_data_r;
    res_found_nxt  = res_found_r;
    res_cnt_nxt    = res_cnt_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_cnt_nxt    = out_cnt_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    mem_ra         = rd_idx_r[AW-1:0];
    mem_wa         = wr_r[AW-1:0];
    mem_wd         = rd_data_r;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          req_nxt        = in_req.req_type;
          val_nxt        = in_req.value;
          res_data_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_cnt_nxt    = '0;
          res_status_nxt = svs_pkg::ST_OK;
          state_nxt      = S_DONE;
          case (in_req.req_type)
            svs_pkg::REQ_PUSH: begin
              if (fill_r == FULL_LVL) begin
                res_status_nxt = svs_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = fill_r[AW-1:0];
                mem_wd   = in_req.value;
                fill_nxt = fill_r + ONE;
              end
            end
            svs_pkg::REQ_POP, svs_pkg::REQ_PEEK: begin
              if (fill_r == '0) begin
                res_status_nxt = svs_pkg::ST_EMPTY;
              end else begin
                mem_ra    = AW'(fill_r - ONE);
                state_nxt = S_TOP;
              end
            end
            svs_pkg::REQ_CONTAINS, svs_pkg::REQ_COUNT, svs_pkg::REQ_REMOVE: begin
              if (fill_r != '0) begin
                mem_ra     = '0;
                rd_idx_nxt = ONE;
                pend_nxt   = 1'b1;
                wr_nxt     = '0;
                cnt_nxt    = '0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Take the top entry; pop drops it
      S_TOP: begin
        res_data_nxt = rd_data_r;
        if (req_r == svs_pkg::REQ_POP) begin
          fill_nxt = fill_r - ONE;
        end
        state_nxt = S_DONE;
      end

      // Walk the stack: issue one read per cycle, check the previous read.
      // Compaction writes land at or below the entry just checked, always
      // under the next read address, so no forwarding is needed.
      S_SCAN: begin
        if (issue) begin
          pend_nxt   = 1'b1;
          rd_idx_nxt = rd_idx_r + ONE;
        end
        if (pend_r) begin
          if (hit) begin
            cnt_nxt = cnt_r + ONE;
          end else if (req_r == svs_pkg::REQ_REMOVE) begin
            mem_we = 1'b1;
            wr_nxt = wr_r + ONE;
          end
        end else begin
          res_found_nxt = (cnt_r != '0);
          res_cnt_nxt   = (req_r == svs_pkg::REQ_CONTAINS) ? '0 : cnt_r;
          if (req_r == svs_pkg::REQ_REMOVE) begin
            fill_nxt = wr_r;
          end
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_found_nxt  = res_found_r;
          out_cnt_nxt    = svs_pkg::CNT_W'(res_cnt_r);
          out_depth_nxt  = svs_pkg::CNT_W'(fill_r);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    wr_r         <= wr_nxt;
    cnt_r        <= cnt_nxt;
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    res_data_r   <= res_data_nxt;
    res_found_r  <= res_found_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Depth never runs past capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_LVL)
    else $error("stack depth exceeds capacity");

  // Accepted push on a non-full stack grows depth by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_req.req_type == svs_pkg::REQ_PUSH && fill_r != FULL_LVL)
      |=> (fill_r == $past(fill_r) + ONE))
    else $error("push did not advance depth");

  // Compaction write pointer stays behind the read pointer
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (wr_r <= rd_idx_r && cnt_r <= rd_idx_r))
    else $error("compaction pointer overtook read pointer");

  // A full status is only reported with the stack at capacity
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == svs_pkg::ST_FULL) |-> (fill_r == FULL_LVL))
    else $error("full status on a stack with room");

endmodule
